// File: rtl/core/frba_pkg.sv
// shared field widths, mode codes and report constants for the frame ring allocator
package frba_pkg;

    // item field widths
    localparam int SIZE_W     = 24;
    localparam int ALIGN_W    = 32;
    localparam int ADDR_W     = 64;
    localparam int TELEM_W    = 21;
    localparam int REPNUM_W   = 32;

    // stream payload widths
    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 144;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (ADDR_W + 1 + TELEM_W + TELEM_W + 1 + REPNUM_W);

    // item kind carried in tuser
    typedef enum logic [IN_TUSER_W-1:0] {
        MODE_ALLOC     = 1'b0,
        MODE_FRAME_END = 1'b1
    } mode_t;

    // budget report rules
    localparam int             REPORT_DIV        = 16;
    localparam logic [REPNUM_W-1:0] REPORT_FIRST = 32'd64;
    localparam logic [5:0]     REPORT_EVERY_MASK = 6'd63;

endpackage

// File: rtl/core/frame_ring_bump_allocator_top.sv
// per-frame bump allocator over a sectioned ring, one request per cycle while m_tready does not stall the result
//
//  channel   dir  handshake                 payload
//  s_*       in   s_tvalid / s_tready       tuser: mode; tdata: size, align
//  m_*       out  m_tvalid / m_tready       tdata: address, ok, peak_used,
//                                           bytes_allocated, report_due, report_number
//  cfg_*     in   cfg_valid / cfg_ready     cfg_data: ring base address
//
//  an item is held in the input register, then the align / fit / address logic loads
//  the result register as soon as that register is free or being drained; the head,
//  peak and byte count change at that same edge, so a new item is taken every cycle
//  while the result register drains
//  a stall on m_tready holds the result and, once the input register is full,
//  drops s_tready; reset clears all allocator state and the ring base to zero
//  cfg_ready is high only while the input register is empty
module frame_ring_bump_allocator_top
    import frba_pkg::*;
#(
    parameter int RING_SIZE   = 4194304,
    parameter int SWAP_COUNT  = 3,
    parameter int ALLOC_ALIGN = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // slave side: tuser = mode; tdata = size [23:0], align [55:24]
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TUSER_W-1:0]  s_tuser,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // master side: tdata = address [63:0], ok [64], peak_used [85:65],
    // bytes_allocated [106:86], report_due [107], report_number [139:108], zero [143:140]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // configuration: ring base address
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [ADDR_W-1:0]      cfg_data
);

    // section geometry
    localparam int SEC_BYTES  = (RING_SIZE / SWAP_COUNT) & ~(ALLOC_ALIGN - 1);
    localparam int PEAK_LIMIT = (RING_SIZE / SWAP_COUNT) / REPORT_DIV;
    localparam int HW         = $clog2(SEC_BYTES + 2);
    localparam int IW         = (SWAP_COUNT > 1) ? $clog2(SWAP_COUNT) : 1;
    localparam int AW         = ALIGN_W + 1;
    localparam int EW         = ALIGN_W + 2;
    localparam int FW         = 26;
    localparam logic [EW-1:0]     SEC_E     = EW'(SEC_BYTES);
    localparam logic [HW-1:0]     SEC_H     = HW'(SEC_BYTES);
    localparam logic [ADDR_W-1:0] SEC_A     = ADDR_W'(SEC_BYTES);
    localparam logic [IW-1:0]     LAST_IDX  = IW'(SWAP_COUNT - 1);
    localparam logic [31:0]       LIMIT_U   = 32'(PEAK_LIMIT);
    localparam logic [ALIGN_W-1:0] DEF_MASK = ALIGN_W'(ALLOC_ALIGN - 1);

    // input register
    logic                in_valid_reg;
    mode_t               in_mode_reg;
    logic [SIZE_W-1:0]   in_size_reg;
    logic [ALIGN_W-1:0]  in_mask_reg;

    // allocator state
    logic [ADDR_W-1:0]   base_addr_reg;
    logic [ADDR_W-1:0]   base_off_reg;
    logic [IW-1:0]       section_index_reg;
    logic [HW-1:0]       head_reg;
    logic [HW-1:0]       peak_reg;
    logic [HW-1:0]       frame_bytes_reg;
    logic [REPNUM_W-1:0] report_count_reg;

    // result register
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_next;

    logic out_free;
    logic fire;

    // effective alignment mask, worked out as the item enters
    logic [ALIGN_W-1:0] align_in;
    logic [ALIGN_W-1:0] align_m1;
    logic               align_pow2;
    logic [ALIGN_W-1:0] mask_in;

    // allocation datapath
    logic [AW-1:0]       sum_a;
    logic [AW-1:0]       aligned;
    logic [EW-1:0]       end_v;
    logic                fits;
    logic                alloc_ok;
    logic [HW-1:0]       new_head;
    logic [FW-1:0]       fb_sum;
    logic [ADDR_W-1:0]   address;

    // frame end datapath
    logic [IW-1:0]       next_idx;
    logic                big_frame;
    logic [REPNUM_W-1:0] count_inc;
    logic [REPNUM_W-1:0] count_new;
    logic                due;
    logic [31:0]         peak_ext;
    logic [31:0]         fb_ext;

    // handshakes
    assign out_free  = !m_tvalid_reg || m_tready;
    assign fire      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = !in_valid_reg;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // alignment check on the incoming item
    assign align_in   = s_tdata[55:24];
    assign align_m1   = align_in - ALIGN_W'(1);
    assign align_pow2 = (align_in != '0) && ((align_in & align_m1) == '0);
    assign mask_in    = align_pow2 ? align_m1 : DEF_MASK;

    // round the head up, then test the fit
    assign sum_a    = AW'(head_reg) + AW'(in_mask_reg);
    assign aligned  = sum_a & ~AW'(in_mask_reg);
    assign end_v    = EW'(aligned) + EW'(in_size_reg);
    assign fits     = end_v <= SEC_E;
    assign alloc_ok = (in_size_reg != '0) && (base_addr_reg != '0) && fits;
    assign new_head = end_v[HW-1:0];
    assign fb_sum   = FW'(frame_bytes_reg) + FW'(in_size_reg);
    assign address  = base_off_reg + ADDR_W'(aligned);

    // frame end bookkeeping
    assign next_idx  = (section_index_reg == LAST_IDX) ? '0 : section_index_reg + IW'(1);
    assign peak_ext  = 32'(peak_reg);
    assign fb_ext    = 32'(frame_bytes_reg);
    assign big_frame = peak_ext > LIMIT_U;
    assign count_inc = report_count_reg + REPNUM_W'(1);
    assign count_new = big_frame ? count_inc : report_count_reg;
    assign due       = big_frame &&
                       ((count_inc <= REPORT_FIRST) || ((count_inc[5:0] & REPORT_EVERY_MASK) == '0));

    // result payload
    always_comb
    begin
        m_tdata_next = '0;
        case (in_mode_reg)
            MODE_FRAME_END:
            begin
                m_tdata_next = {OUT_PAD_W'(0), count_new, due, fb_ext[TELEM_W-1:0],
                                peak_ext[TELEM_W-1:0], 1'b1, ADDR_W'(0)};
            end
            MODE_ALLOC:
            begin
                if (alloc_ok)
                begin
                    m_tdata_next = {OUT_PAD_W'(0), REPNUM_W'(0), 1'b0, TELEM_W'(0),
                                    TELEM_W'(0), 1'b1, address};
                end
            end
            default:
            begin
                m_tdata_next = '0;
            end
        endcase
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_mode_reg <= mode_t'(s_tuser);
            in_size_reg <= s_tdata[23:0];
            in_mask_reg <= mask_in;
        end
    end

    // allocator state and ring base
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_addr_reg     <= '0;
            base_off_reg      <= '0;
            section_index_reg <= '0;
            head_reg          <= '0;
            peak_reg          <= '0;
            frame_bytes_reg   <= '0;
            report_count_reg  <= '0;
        end
        else if (fire && (in_mode_reg == MODE_FRAME_END))
        begin
            section_index_reg <= next_idx;
            base_off_reg      <= (section_index_reg == LAST_IDX) ? base_addr_reg
                                                                 : base_off_reg + SEC_A;
            head_reg          <= '0;
            peak_reg          <= '0;
            frame_bytes_reg   <= '0;
            report_count_reg  <= count_new;
        end
        else if (fire && alloc_ok)
        begin
            head_reg        <= new_head;
            peak_reg        <= (new_head > peak_reg) ? new_head : peak_reg;
            frame_bytes_reg <= fb_sum[HW-1:0];
        end
        else if (cfg_valid && cfg_ready)
        begin
            base_addr_reg <= cfg_data;
            base_off_reg  <= cfg_data + ADDR_W'(section_index_reg) * SEC_A;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_tvalid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // section index stays inside the ring
    assert property (@(posedge clk) disable iff (!rst_n)
        section_index_reg <= LAST_IDX)
        else $error("section index beyond last section");

    // head never passes the end of its section
    assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= SEC_H)
        else $error("head beyond section end");

    // peak tracks the head, and the byte count never exceeds it
    assert property (@(posedge clk) disable iff (!rst_n)
        (peak_reg >= head_reg) && (frame_bytes_reg <= head_reg))
        else $error("peak or byte count out of step with head");

    // frame end starts the next frame empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (in_mode_reg == MODE_FRAME_END)) |=>
            ((head_reg == '0) && (peak_reg == '0) && (frame_bytes_reg == '0)))
        else $error("frame state not cleared after frame end");

    // a failed result carries nothing but zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tdata_reg[64]) |-> (m_tdata_reg == '0))
        else $error("failed allocation with non-zero payload");

endmodule

// File: verif/frame_ring_bump_allocator_tb.sv
// self-checking testbench for the frame ring bump allocator: directed corner cases, then random frames
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import frba_pkg::*;

    localparam int RING_SIZE    = 4194304;
    localparam int SWAP_COUNT   = 3;
    localparam int ALLOC_ALIGN  = 256;
    localparam int SECTION_LEN  = (RING_SIZE / SWAP_COUNT) & ~(ALLOC_ALIGN - 1);
    localparam logic [ADDR_W-1:0] SECTION_BYTES = ADDR_W'(SECTION_LEN);
    localparam int BUDGET_LIMIT = (RING_SIZE / SWAP_COUNT) / REPORT_DIV;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTED = 10;
    localparam int PHASE_ITEMS  = 460;

    // result item as carried on m_tdata, address in the lowest bits
    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic [REPNUM_W-1:0]  report_number;
        logic                 report_due;
        logic [TELEM_W-1:0]   bytes_allocated;
        logic [TELEM_W-1:0]   peak_used;
        logic                 ok;
        logic [ADDR_W-1:0]    address;
    } alloc_result_t;

    typedef enum int {
        PHASE_DIRECTED,
        PHASE_SLOW_SINK,
        PHASE_SLOW_SOURCE,
        PHASE_FREE
    } phase_t;

    // allocator shadow: predicts each result and checks the block's results in order
    class alloc_ledger;
        logic [ADDR_W-1:0]   base_addr;
        logic [TELEM_W-1:0]  head;
        logic [TELEM_W-1:0]  peak;
        logic [TELEM_W-1:0]  frame_bytes;
        int unsigned         section;
        logic [REPNUM_W-1:0] report_count;
        alloc_result_t       expected_results[$];
        int                  mismatches;
        int                  results_seen;
        int                  requests;
        int                  frame_ends;
        int                  grants;
        int                  reports;

        function new();
            base_addr    = '0;
            head         = '0;
            peak         = '0;
            frame_bytes  = '0;
            section      = 0;
            report_count = '0;
            mismatches   = 0;
            results_seen = 0;
            requests     = 0;
            frame_ends   = 0;
            grants       = 0;
            reports      = 0;
        endfunction

        // work out the result of one accepted request and update the shadow state
        function void note_request(mode_t kind, logic [SIZE_W-1:0] size,
                                   logic [ALIGN_W-1:0] align);
            alloc_result_t     r;
            logic [ADDR_W-1:0] step;
            logic [ADDR_W-1:0] aligned;
            r = '0;
            requests++;
            if (kind == MODE_FRAME_END) begin
                frame_ends++;
                r.ok              = 1'b1;
                r.peak_used       = peak;
                r.bytes_allocated = frame_bytes;
                section           = (section + 1) % SWAP_COUNT;
                head              = '0;
                // large frame: count it, flag the first 64 and every 64th after
                if (peak > TELEM_W'(BUDGET_LIMIT)) begin
                    report_count = report_count + 1'b1;
                    if (report_count <= REPORT_FIRST ||
                        (report_count[5:0] & REPORT_EVERY_MASK) == 6'd0)
                        r.report_due = 1'b1;
                end
                if (r.report_due)
                    reports++;
                r.report_number = report_count;
                peak            = '0;
                frame_bytes     = '0;
            end
            else if (size != '0 && base_addr != '0) begin
                // zero or non power of two alignment falls back to the default
                if (align != '0 && (align & (align - 1'b1)) == '0)
                    step = ADDR_W'(align);
                else
                    step = ADDR_W'(ALLOC_ALIGN);
                aligned = (ADDR_W'(head) + step - 1'b1) & ~(step - 1'b1);
                if (aligned + ADDR_W'(size) <= SECTION_BYTES) begin
                    head = TELEM_W'(aligned + ADDR_W'(size));
                    if (head > peak)
                        peak = head;
                    frame_bytes = frame_bytes + TELEM_W'(size);
                    r.ok        = 1'b1;
                    r.address   = base_addr + ADDR_W'(section) * SECTION_BYTES + aligned;
                    grants++;
                end
            end
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [ADDR_W-1:0] want,
                                    logic [ADDR_W-1:0] have);
            if (want !== have) begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("result %0d: %s expected 0x%0h, got 0x%0h",
                             results_seen, name, want, have);
            end
        endfunction

        // compare one accepted result with the oldest prediction
        function void check_result(logic [OUT_TDATA_W-1:0] tdata);
            alloc_result_t got;
            alloc_result_t want;
            got = alloc_result_t'(tdata);
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("result %0d arrived with nothing outstanding: 0x%0h",
                             results_seen, tdata);
                return;
            end
            want = expected_results.pop_front();
            compare_field("address", want.address, got.address);
            compare_field("ok", ADDR_W'(want.ok), ADDR_W'(got.ok));
            compare_field("peak_used", ADDR_W'(want.peak_used), ADDR_W'(got.peak_used));
            compare_field("bytes_allocated", ADDR_W'(want.bytes_allocated),
                          ADDR_W'(got.bytes_allocated));
            compare_field("report_due", ADDR_W'(want.report_due), ADDR_W'(got.report_due));
            compare_field("report_number", ADDR_W'(want.report_number),
                          ADDR_W'(got.report_number));
            compare_field("padding", ADDR_W'(want.pad), ADDR_W'(got.pad));
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TUSER_W-1:0]  s_tuser;     // mode
    logic [IN_TDATA_W-1:0]  s_tdata;     // size, align
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;     // address, ok, peak_used, bytes_allocated,
                                         // report_due, report_number, zero padding
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [ADDR_W-1:0]      cfg_data;    // ring base address

    alloc_ledger ledger;
    phase_t      phase = PHASE_DIRECTED;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          quiet_cycles = 0;

    frame_ring_bump_allocator_top #(
        .RING_SIZE   (RING_SIZE),
        .SWAP_COUNT  (SWAP_COUNT),
        .ALLOC_ALIGN (ALLOC_ALIGN)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // result sink: random back-pressure, plus one long hold-off in the free-running phase
    always @(posedge clk)
    begin
        if (phase == PHASE_FREE && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // check every accepted result item
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            ledger.check_result(m_tdata);
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: %0d cycles without a handshake", STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // offer one request item after random idle cycles and wait for acceptance
    task automatic send_item(input mode_t kind, input logic [SIZE_W-1:0] size,
                             input logic [ALIGN_W-1:0] align);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {align, size};
        do @(posedge clk); while (!s_tready);
        ledger.note_request(kind, size, align);
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (ledger.expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ring base write, only while the block is idle
    task automatic write_ring_base(input logic [ADDR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        ledger.base_addr = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // random frames of allocations, each closed by a frame end
    task automatic run_phase(input phase_t p, input int src_idle, input int sink_idle,
                             input logic [ADDR_W-1:0] base);
        int unsigned        sent;
        int unsigned        n_allocs;
        int unsigned        pick;
        logic [SIZE_W-1:0]  size;
        logic [ALIGN_W-1:0] align;
        drain();
        write_ring_base(base);
        phase         = p;
        send_idle_pct = src_idle;
        recv_idle_pct = sink_idle;
        sent          = 0;
        while (sent < PHASE_ITEMS)
        begin
            n_allocs = $urandom_range(8);
            repeat (n_allocs)
            begin
                // mostly small sizes, a fair share above the budget line, a few huge
                pick = $urandom_range(99);
                if (pick < 8)
                    size = '0;
                else if (pick < 18)
                    size = SIZE_W'($urandom);
                else if (pick < 21)
                    size = SIZE_W'($urandom_range(SECTION_LEN, SECTION_LEN / 2));
                else if (pick < 40)
                    size = SIZE_W'($urandom_range(300000, BUDGET_LIMIT + 1));
                else
                    size = SIZE_W'($urandom_range(4096, 1));
                // powers of two mostly, some zero and arbitrary values
                pick = $urandom_range(99);
                if (pick < 10)
                    align = '0;
                else if (pick < 25)
                    align = $urandom;
                else if (pick < 30)
                    align = ALIGN_W'(1) << $urandom_range(31, 13);
                else
                    align = ALIGN_W'(1) << $urandom_range(12, 0);
                send_item(MODE_ALLOC, size, align);
            end
            send_item(MODE_FRAME_END, SIZE_W'($urandom), $urandom);
            sent += n_allocs + 1;
        end
    endtask

    // reset, directed corner cases, then three random phases
    initial
    begin
        ledger = new();
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= MODE_ALLOC;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no ring: allocations fail
        write_ring_base('0);
        send_item(MODE_ALLOC, 24'd16, 32'd0);
        drain();
        write_ring_base(64'h0000_0010_0000_0000);

        // zero size, alignment fallbacks and an oversized alignment
        send_item(MODE_ALLOC, 24'd0, 32'd256);
        send_item(MODE_ALLOC, 24'd1, 32'd1);
        send_item(MODE_ALLOC, 24'd100, 32'd0);
        send_item(MODE_ALLOC, 24'd8, 32'd3);
        send_item(MODE_ALLOC, 24'd8, 32'hFFFF_FFFF);
        send_item(MODE_ALLOC, 24'd8, 32'h8000_0000);
        send_item(MODE_ALLOC, 24'hFF_FFFF, 32'd16);
        send_item(MODE_ALLOC, 24'd4096, 32'd4096);
        send_item(MODE_FRAME_END, 24'd0, 32'd0);

        // whole section, then exhausted; large frame reported
        send_item(MODE_ALLOC, SIZE_W'(SECTION_LEN), 32'd1);
        send_item(MODE_ALLOC, 24'd1, 32'd1);
        send_item(MODE_FRAME_END, 24'hFF_FFFF, 32'hFFFF_FFFF);

        // peak exactly on the budget line, then one byte over
        send_item(MODE_ALLOC, SIZE_W'(BUDGET_LIMIT), 32'd1);
        send_item(MODE_FRAME_END, 24'd0, 32'd0);
        send_item(MODE_ALLOC, SIZE_W'(BUDGET_LIMIT + 1), 32'd8);
        send_item(MODE_FRAME_END, 24'd0, 32'd0);
        send_item(MODE_ALLOC, 24'd32, 32'h8000_0000);
        send_item(MODE_ALLOC, 24'd64, 32'd2);

        // base change mid-frame keeps the head; address wraps past the top
        drain();
        write_ring_base(64'hFFFF_FFFF_FFFF_FF00);
        send_item(MODE_ALLOC, 24'd512, 32'd64);
        send_item(MODE_ALLOC, 24'd16, 32'd16);
        send_item(MODE_FRAME_END, 24'd0, 32'd0);

        run_phase(PHASE_SLOW_SINK, 20, 87, {$urandom, $urandom} | 64'h1);
        run_phase(PHASE_SLOW_SOURCE, 87, 20, '1);
        run_phase(PHASE_FREE, 0, 0, {$urandom, $urandom} | 64'h1);

        drain();
        repeat (8) @(posedge clk);

        $display("covered %0d request items: %0d frame ends, %0d granted, %0d reports flagged",
                 ledger.requests, ledger.frame_ends, ledger.grants, ledger.reports);
        $display("ring base zero, low, near and at the top, random; sink hold-off %0d cycles",
                 HOLD_CYCLES);
        if (ledger.mismatches == 0 && ledger.expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
